// File: rtl/core/assert_macros.svh
// assertion helpers shared by the gap buffer rtl
// no dependencies; include guarded
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define GBTS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled while reset is asserted
`define GBTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/core/gbts_pkg.sv
// gbts_pkg: sizes, opcodes, status codes, fsm states and request/result structs
// for the gap buffer text store; no dependencies
`timescale 1ns / 1ps

package gbts_pkg;

  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int LEN_W    = ADDR_W + 1;
  localparam int CP_W     = 21;
  localparam int IDX_W    = 13;
  localparam int DELTA_W  = 12;
  localparam int STAT_W   = 2;
  localparam int OP_W     = 3;

  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
  localparam logic [OP_W-1:0] OP_MOVE   = 3'd2;
  localparam logic [OP_W-1:0] OP_READ   = 3'd3;
  localparam logic [OP_W-1:0] OP_L2S    = 3'd4;
  localparam logic [OP_W-1:0] OP_S2L    = 3'd5;
  localparam logic [OP_W-1:0] OP_ADJUST = 3'd6;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RDWAIT,
    S_MOVE,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [OP_W-1:0]           opcode;
    logic [CP_W-1:0]           codepoint;
    logic [LEN_W-1:0]          logical_index;
    logic [LEN_W-1:0]          buffer_index;
    logic signed [DELTA_W-1:0] delta;
  } req_t;

  typedef struct packed {
    logic [CP_W-1:0]         read_data;
    logic signed [IDX_W-1:0] index_out;
    logic [STAT_W-1:0]       status;
    logic [LEN_W-1:0]        content_length;
    logic [LEN_W-1:0]        gap_position;
  } res_t;

endpackage

// File: rtl/core/gbts_ram.sv
// gbts_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module gbts_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 21,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/gbts_ctrl.sv
// gbts_ctrl: opcode sequencer, gap pointers, index mapping and gap-move copy engine
// depends on gbts_pkg and assert_macros.svh; drives the store ram ports
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gbts_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  gbts_pkg::req_t                req,
  output logic                          res_valid,
  input  logic                          res_ready,
  output gbts_pkg::res_t                res,
  output logic                          ram_wr_en,
  output logic [gbts_pkg::ADDR_W-1:0]   ram_wr_addr,
  output logic [gbts_pkg::CP_W-1:0]     ram_wr_data,
  output logic                          ram_rd_en,
  output logic [gbts_pkg::ADDR_W-1:0]   ram_rd_addr,
  input  logic [gbts_pkg::CP_W-1:0]     ram_rd_data
);

  localparam int LW = gbts_pkg::LEN_W;
  localparam int AW = gbts_pkg::ADDR_W;
  localparam int XW = gbts_pkg::IDX_W + 1;
  localparam logic [LW-1:0] CAP_L = LW'(gbts_pkg::CAPACITY);

  gbts_pkg::state_t state_r, state_nxt;
  gbts_pkg::req_t   req_r, req_nxt;

  logic [LW-1:0] front_r, front_nxt;
  logic [LW-1:0] gap_r, gap_nxt;

  logic [gbts_pkg::CP_W-1:0]         res_data_r, res_data_nxt;
  logic signed [gbts_pkg::IDX_W-1:0] res_idx_r, res_idx_nxt;
  logic [gbts_pkg::STAT_W-1:0]       res_stat_r, res_stat_nxt;

  logic [LW-1:0] mv_cnt_r, mv_cnt_nxt;
  logic [AW-1:0] mv_src_r, mv_src_nxt;
  logic [AW-1:0] mv_dst_r, mv_dst_nxt;
  logic          mv_fwd_r, mv_fwd_nxt;
  logic          mv_pend_r, mv_pend_nxt;

  logic [LW-1:0] content_len;
  logic [LW-1:0] gap_end;
  logic [LW-1:0] li;
  logic [LW-1:0] bi;
  logic [LW-1:0] li_phys;
  logic [LW:0]   fg_sum;

  logic signed [XW-1:0] x_s, d_s, gb_s, ge_s, g_s, sum_s, adj_s;

  assign content_len = CAP_L - gap_r;
  assign gap_end     = front_r + gap_r;
  assign fg_sum      = {1'b0, front_r} + {1'b0, gap_r};
  assign li          = req_r.logical_index;
  assign bi          = req_r.buffer_index;
  assign li_phys     = (li < front_r) ? li : li + gap_r;

  // adjust: step a store index by delta, hopping over the gap
  assign x_s   = $signed(XW'(bi));
  assign d_s   = XW'(req_r.delta);
  assign gb_s  = $signed(XW'(front_r));
  assign ge_s  = $signed(XW'(gap_end));
  assign g_s   = $signed(XW'(gap_r));
  assign sum_s = x_s + d_s;

  always_comb begin
    if (x_s >= ge_s) begin
      adj_s = (sum_s < ge_s) ? sum_s - g_s : sum_s;
    end else begin
      adj_s = (sum_s >= gb_s) ? sum_s + g_s : sum_s;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= gbts_pkg::S_IDLE;
      front_r   <= '0;
      gap_r     <= CAP_L;
      mv_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      front_r   <= front_nxt;
      gap_r     <= gap_nxt;
      mv_pend_r <= mv_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    res_data_r <= res_data_nxt;
    res_idx_r  <= res_idx_nxt;
    res_stat_r <= res_stat_nxt;
    mv_cnt_r   <= mv_cnt_nxt;
    mv_src_r   <= mv_src_nxt;
    mv_dst_r   <= mv_dst_nxt;
    mv_fwd_r   <= mv_fwd_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    req_nxt      = req_r;
    front_nxt    = front_r;
    gap_nxt      = gap_r;
    res_data_nxt = res_data_r;
    res_idx_nxt  = res_idx_r;
    res_stat_nxt = res_stat_r;
    mv_cnt_nxt   = mv_cnt_r;
    mv_src_nxt   = mv_src_r;
    mv_dst_nxt   = mv_dst_r;
    mv_fwd_nxt   = mv_fwd_r;
    mv_pend_nxt  = 1'b0;
    req_ready    = 1'b0;
    res_valid    = 1'b0;
    ram_wr_en    = 1'b0;
    ram_wr_addr  = '0;
    ram_wr_data  = '0;
    ram_rd_en    = 1'b0;
    ram_rd_addr  = '0;

    unique case (state_r)
      gbts_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          req_nxt   = req;
          state_nxt = gbts_pkg::S_EXEC;
        end
      end

      gbts_pkg::S_EXEC: begin
        res_data_nxt = '0;
        res_idx_nxt  = '0;
        res_stat_nxt = gbts_pkg::STAT_OK;
        state_nxt    = gbts_pkg::S_RESP;
        unique case (req_r.opcode)
          gbts_pkg::OP_CLEAR: begin
            front_nxt = '0;
            gap_nxt   = CAP_L;
          end
          gbts_pkg::OP_INSERT: begin
            // one slot always stays free
            if (gap_r <= LW'(1)) begin
              res_stat_nxt = gbts_pkg::STAT_FULL;
            end else begin
              ram_wr_en   = 1'b1;
              ram_wr_addr = front_r[AW-1:0];
              ram_wr_data = req_r.codepoint;
              front_nxt   = front_r + LW'(1);
              gap_nxt     = gap_r - LW'(1);
            end
          end
          gbts_pkg::OP_MOVE: begin
            if (li > content_len) begin
              res_stat_nxt = gbts_pkg::STAT_RANGE;
            end else if (li > front_r) begin
              mv_fwd_nxt = 1'b1;
              mv_cnt_nxt = li - front_r;
              mv_src_nxt = gap_end[AW-1:0];
              mv_dst_nxt = front_r[AW-1:0];
              state_nxt  = gbts_pkg::S_MOVE;
            end else if (li < front_r) begin
              mv_fwd_nxt = 1'b0;
              mv_cnt_nxt = front_r - li;
              mv_src_nxt = AW'(front_r - LW'(1));
              mv_dst_nxt = AW'(gap_end - LW'(1));
              state_nxt  = gbts_pkg::S_MOVE;
            end
          end
          gbts_pkg::OP_READ: begin
            if (li >= content_len) begin
              res_stat_nxt = gbts_pkg::STAT_RANGE;
            end else begin
              ram_rd_en   = 1'b1;
              ram_rd_addr = li_phys[AW-1:0];
              state_nxt   = gbts_pkg::S_RDWAIT;
            end
          end
          gbts_pkg::OP_L2S: begin
            if (li > content_len) begin
              res_stat_nxt = gbts_pkg::STAT_RANGE;
            end else begin
              res_idx_nxt = $signed(gbts_pkg::IDX_W'(li_phys));
            end
          end
          gbts_pkg::OP_S2L: begin
            if (bi > CAP_L) begin
              res_stat_nxt = gbts_pkg::STAT_RANGE;
            end else if (bi < front_r) begin
              res_idx_nxt = $signed(gbts_pkg::IDX_W'(bi));
            end else if (bi < gap_end) begin
              res_idx_nxt  = '1;
              res_stat_nxt = gbts_pkg::STAT_RANGE;
            end else begin
              res_idx_nxt = $signed(gbts_pkg::IDX_W'(bi - gap_r));
            end
          end
          gbts_pkg::OP_ADJUST: begin
            if (bi > CAP_L) begin
              res_stat_nxt = gbts_pkg::STAT_RANGE;
            end else begin
              res_idx_nxt = adj_s[gbts_pkg::IDX_W-1:0];
            end
          end
          default: begin
            res_stat_nxt = gbts_pkg::STAT_RANGE;
          end
        endcase
      end

      gbts_pkg::S_RDWAIT: begin
        res_data_nxt = ram_rd_data;
        state_nxt    = gbts_pkg::S_RESP;
      end

      gbts_pkg::S_MOVE: begin
        // reads run ahead of writes, each write landing in the cycle after its read; source and destination
        // never meet in the same cycle, so no forwarding is needed
        if (mv_cnt_r != '0) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = mv_src_r;
          mv_cnt_nxt  = mv_cnt_r - LW'(1);
          mv_src_nxt  = mv_fwd_r ? mv_src_r + AW'(1) : mv_src_r - AW'(1);
          mv_pend_nxt = 1'b1;
        end
        if (mv_pend_r) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = mv_dst_r;
          ram_wr_data = ram_rd_data;
          mv_dst_nxt  = mv_fwd_r ? mv_dst_r + AW'(1) : mv_dst_r - AW'(1);
        end
        if ((mv_cnt_r == '0) && mv_pend_r) begin
          front_nxt = li;
          state_nxt = gbts_pkg::S_RESP;
        end
      end

      gbts_pkg::S_RESP: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = gbts_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = gbts_pkg::S_IDLE;
      end
    endcase
  end

  assign res.read_data      = res_data_r;
  assign res.index_out      = res_idx_r;
  assign res.status         = res_stat_r;
  assign res.content_length = content_len;
  assign res.gap_position   = front_r;

  `GBTS_ASSERT_IMPL(a_gap_fits, clk, rst_n, 1'b1, fg_sum <= {1'b0, CAP_L})
  `GBTS_ASSERT_IMPL(a_gap_nonzero, clk, rst_n, 1'b1, gap_r != '0)
  `GBTS_ASSERT_IMPL(a_wr_busy_only, clk, rst_n, ram_wr_en, state_r != gbts_pkg::S_IDLE)
  `GBTS_ASSERT_NEXT(a_move_ends, clk, rst_n,
                    (state_r == gbts_pkg::S_MOVE) && (mv_cnt_r == '0) && mv_pend_r,
                    front_r == req_r.logical_index)

endmodule

// File: rtl/core/gap_buffer_text_store.sv
// gap_buffer_text_store: top level, stream ports, result register, store ram
// depends on gbts_pkg, gbts_ram, gbts_ctrl and assert_macros.svh
// each request passes the sequencer states exec, then rdwait for read or move for a gap move,
// then resp and the result register; a new request is taken only after the last result is handed on
// a move copies one entry per cycle through the single write port of the store ram
// reset: empty text, gap at 0 spanning the whole store; ram contents are not cleared
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gap_buffer_text_store (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,  // codepoint, logical_index, buffer_index, delta
  input  logic [2:0]  in_tuser,  // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata  // read_data, index_out, status, content_length,
                                 // gap_position
);

  gbts_pkg::req_t req;
  gbts_pkg::res_t res;
  logic           res_valid;
  logic           res_ready;

  logic                          ram_wr_en;
  logic [gbts_pkg::ADDR_W-1:0]   ram_wr_addr;
  logic [gbts_pkg::CP_W-1:0]     ram_wr_data;
  logic                          ram_rd_en;
  logic [gbts_pkg::ADDR_W-1:0]   ram_rd_addr;
  logic [gbts_pkg::CP_W-1:0]     ram_rd_data;

  logic           out_valid_r, out_valid_nxt;
  gbts_pkg::res_t out_res_r, out_res_nxt;

  assign req.opcode        = in_tuser;
  assign req.codepoint     = in_tdata[20:0];
  assign req.logical_index = in_tdata[31:21];
  assign req.buffer_index  = in_tdata[42:32];
  assign req.delta         = $signed(in_tdata[54:43]);

  gbts_ram #(
    .DEPTH (gbts_pkg::CAPACITY),
    .WIDTH (gbts_pkg::CP_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  gbts_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (in_tvalid),
    .req_ready   (in_tready),
    .req         (req),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data)
  );

  // the result register holds one result while the sink stalls; the sequencer waits only when it is full
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_ready) begin
      out_valid_nxt = res_valid;
      if (res_valid) begin
        out_res_nxt = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid        = out_valid_r;
  assign out_tdata[20:0]   = out_res_r.read_data;
  assign out_tdata[33:21]  = out_res_r.index_out;
  assign out_tdata[35:34]  = out_res_r.status;
  assign out_tdata[46:36]  = out_res_r.content_length;
  assign out_tdata[57:47]  = out_res_r.gap_position;
  assign out_tdata[63:58]  = '0;

  `GBTS_ASSERT_NEXT(a_res_lands, clk, rst_n, res_valid && res_ready, out_valid_r)

endmodule

// File: bench/tb_gap_buffer_text_store.sv
// tb_gap_buffer_text_store: self-checking bench for the gap buffer text store
// directed table and random traffic under several idling phases, checked against a local model
// depends on gbts_pkg and gap_buffer_text_store
`timescale 1ns / 1ps

module tb_gap_buffer_text_store;

  localparam logic [gbts_pkg::OP_W-1:0] OP_UNKNOWN = 3'd7;
  localparam int CP_MAX = 32'h10FFFF;
  localparam int CYCLE_LIMIT = 3_000_000;

  typedef struct {
    gbts_pkg::req_t rq;
    bit             typed;
    gbts_pkg::res_t res;
  } dir_row_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;  // codepoint, logical_index, buffer_index, delta
  logic [2:0]  in_tuser = '0;  // opcode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;      // read_data, index_out, status, content_length,
                               // gap_position

  gap_buffer_text_store dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // local copy of the text store
  logic [gbts_pkg::CP_W-1:0] text_mem [gbts_pkg::CAPACITY];
  int front_len;
  int gap_len;

  gbts_pkg::res_t expected_results [$];
  dir_row_t       directed_rows [$];
  int             mismatch_count;
  int             cycle_count;
  int             send_idle_pct;
  int             recv_stall_pct;
  gbts_pkg::res_t got_res;
  gbts_pkg::res_t want_res;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout with %0d results pending", expected_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch in %s: got 0x%0h, expected 0x%0h", what, got, want);
    mismatch_count++;
  endtask

  // one gap buffer operation applied to the local copy
  function automatic gbts_pkg::res_t apply_edit(gbts_pkg::req_t r);
    gbts_pkg::res_t o;
    int li, bi, dl, i, gb, ge, x, adj, content;
    o = '0;
    li = int'(r.logical_index);
    bi = int'(r.buffer_index);
    dl = int'(r.delta);
    content = gbts_pkg::CAPACITY - gap_len;
    case (r.opcode)
      gbts_pkg::OP_CLEAR: begin
        front_len = 0;
        gap_len = gbts_pkg::CAPACITY;
      end
      gbts_pkg::OP_INSERT: begin
        if (gap_len <= 1) begin
          o.status = gbts_pkg::STAT_FULL;
        end else begin
          text_mem[front_len] = r.codepoint;
          front_len++;
          gap_len--;
        end
      end
      gbts_pkg::OP_MOVE: begin
        if (li > content) begin
          o.status = gbts_pkg::STAT_RANGE;
        end else if (li > front_len) begin
          for (i = 0; i < li - front_len; i++)
            text_mem[front_len + i] = text_mem[front_len + gap_len + i];
          front_len = li;
        end else if (li < front_len) begin
          for (i = front_len - li; i > 0; i--)
            text_mem[li + gap_len + i - 1] = text_mem[li + i - 1];
          front_len = li;
        end
      end
      gbts_pkg::OP_READ: begin
        if (li >= content) o.status = gbts_pkg::STAT_RANGE;
        else o.read_data = text_mem[(li < front_len) ? li : li + gap_len];
      end
      gbts_pkg::OP_L2S: begin
        if (li > content) o.status = gbts_pkg::STAT_RANGE;
        else o.index_out = gbts_pkg::IDX_W'((li < front_len) ? li : li + gap_len);
      end
      gbts_pkg::OP_S2L: begin
        if (bi > gbts_pkg::CAPACITY) begin
          o.status = gbts_pkg::STAT_RANGE;
        end else if (bi < front_len) begin
          o.index_out = gbts_pkg::IDX_W'(bi);
        end else if (bi < front_len + gap_len) begin
          o.index_out = '1;
          o.status = gbts_pkg::STAT_RANGE;
        end else begin
          o.index_out = gbts_pkg::IDX_W'(bi - gap_len);
        end
      end
      gbts_pkg::OP_ADJUST: begin
        if (bi > gbts_pkg::CAPACITY) begin
          o.status = gbts_pkg::STAT_RANGE;
        end else begin
          x = bi;
          gb = front_len;
          ge = front_len + gap_len;
          // a step that reaches or passes the gap is carried across it
          if (x >= ge) adj = (x + dl < ge) ? x - gap_len + dl : x + dl;
          else adj = (x + dl >= gb) ? x + gap_len + dl : x + dl;
          o.index_out = gbts_pkg::IDX_W'(adj);
        end
      end
      default: o.status = gbts_pkg::STAT_RANGE;
    endcase
    o.content_length = gbts_pkg::LEN_W'(gbts_pkg::CAPACITY - gap_len);
    o.gap_position = gbts_pkg::LEN_W'(front_len);
    return o;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_res.read_data      = out_tdata[20:0];
      got_res.index_out      = out_tdata[33:21];
      got_res.status         = out_tdata[35:34];
      got_res.content_length = out_tdata[46:36];
      got_res.gap_position   = out_tdata[57:47];
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing pending", out_tdata[31:0], 32'd0);
      end else begin
        want_res = expected_results.pop_front();
        if (got_res.read_data !== want_res.read_data)
          report_mismatch("read_data", 32'(got_res.read_data), 32'(want_res.read_data));
        if (got_res.index_out !== want_res.index_out)
          report_mismatch("index_out", 32'(got_res.index_out), 32'(want_res.index_out));
        if (got_res.status !== want_res.status)
          report_mismatch("status", 32'(got_res.status), 32'(want_res.status));
        if (got_res.content_length !== want_res.content_length)
          report_mismatch("content_length", 32'(got_res.content_length),
                          32'(want_res.content_length));
        if (got_res.gap_position !== want_res.gap_position)
          report_mismatch("gap_position", 32'(got_res.gap_position),
                          32'(want_res.gap_position));
      end
    end
  end

  // holds the transfer until accepted, then records what should come back and may idle at random
  task automatic push_request(input gbts_pkg::req_t r, input bit typed,
                              input gbts_pkg::res_t typed_res);
    gbts_pkg::res_t p;
    in_tvalid <= 1'b1;
    in_tuser  <= r.opcode;
    in_tdata  <= {1'b0, r.delta, r.buffer_index, r.logical_index, r.codepoint};
    do @(posedge clk); while (!in_tready);
    p = apply_edit(r);
    expected_results.push_back(typed ? typed_res : p);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  function automatic void add_row(input logic [gbts_pkg::OP_W-1:0] op, input int cp,
                                  input int li, input int bi, input int dl,
                                  input bit typed, input int rd, input int idx,
                                  input int st, input int len, input int gp);
    dir_row_t row;
    row.rq.opcode = op;
    row.rq.codepoint = cp[gbts_pkg::CP_W-1:0];
    row.rq.logical_index = li[gbts_pkg::LEN_W-1:0];
    row.rq.buffer_index = bi[gbts_pkg::LEN_W-1:0];
    row.rq.delta = dl[gbts_pkg::DELTA_W-1:0];
    row.typed = typed;
    row.res.read_data = rd[gbts_pkg::CP_W-1:0];
    row.res.index_out = idx[gbts_pkg::IDX_W-1:0];
    row.res.status = st[gbts_pkg::STAT_W-1:0];
    row.res.content_length = len[gbts_pkg::LEN_W-1:0];
    row.res.gap_position = gp[gbts_pkg::LEN_W-1:0];
    directed_rows.push_back(row);
  endfunction

  function automatic gbts_pkg::req_t random_request(input logic [gbts_pkg::OP_W-1:0] op);
    gbts_pkg::req_t r;
    int content;
    content = gbts_pkg::CAPACITY - gap_len;
    r.opcode = op;
    case ($urandom_range(0, 19))
      0: r.codepoint = '0;
      1: r.codepoint = gbts_pkg::CP_W'(CP_MAX);
      default: r.codepoint = gbts_pkg::CP_W'($urandom_range(0, CP_MAX));
    endcase
    // mostly indices inside the text, now and then anything the field holds
    if ($urandom_range(0, 9) == 0) begin
      r.logical_index = gbts_pkg::LEN_W'($urandom);
    end else if (op == gbts_pkg::OP_READ && content > 0) begin
      r.logical_index = gbts_pkg::LEN_W'($urandom_range(0, content - 1));
    end else begin
      r.logical_index = gbts_pkg::LEN_W'($urandom_range(0, content));
    end
    if ($urandom_range(0, 9) < 2) r.buffer_index = gbts_pkg::LEN_W'($urandom);
    else r.buffer_index = gbts_pkg::LEN_W'($urandom_range(0, gbts_pkg::CAPACITY));
    if ($urandom_range(0, 9) < 2) r.delta = gbts_pkg::DELTA_W'($urandom);
    else r.delta = gbts_pkg::DELTA_W'($urandom_range(0, 2048) - 1024);
    return r;
  endfunction

  task automatic run_random(input int count);
    gbts_pkg::req_t r;
    int pick, k;
    logic [gbts_pkg::OP_W-1:0] op;
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) op = gbts_pkg::OP_CLEAR;
      else if (pick < 35) op = gbts_pkg::OP_INSERT;
      else if (pick < 48) op = gbts_pkg::OP_MOVE;
      else if (pick < 63) op = gbts_pkg::OP_READ;
      else if (pick < 73) op = gbts_pkg::OP_L2S;
      else if (pick < 84) op = gbts_pkg::OP_S2L;
      else if (pick < 97) op = gbts_pkg::OP_ADJUST;
      else op = OP_UNKNOWN;
      r = random_request(op);
      push_request(r, 1'b0, '0);
    end
  endtask

  initial begin
    int k;
    mismatch_count = 0;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    front_len = 0;
    gap_len = gbts_pkg::CAPACITY;
    for (k = 0; k < gbts_pkg::CAPACITY; k++) text_mem[k] = '0;

    // op, codepoint, logical, buffer, delta, typed, read_data, index, status, len, gap
    add_row(gbts_pkg::OP_READ,   0,        0,    0,    0,     1, 0, 0,  2, 0, 0);
    add_row(gbts_pkg::OP_S2L,    0,        0,    0,    0,     1, 0, -1, 2, 0, 0);
    add_row(gbts_pkg::OP_L2S,    0,        0,    0,    0,     1, 0, 1024, 0, 0, 0);
    add_row(gbts_pkg::OP_INSERT, CP_MAX,   0,    0,    0,     1, 0, 0,  0, 1, 1);
    add_row(gbts_pkg::OP_INSERT, 0,        2047, 2047, -1,    1, 0, 0,  0, 2, 2);
    add_row(gbts_pkg::OP_INSERT, 'h0AAAAA, 0,    0,    0,     0, 0, 0,  0, 0, 0);
    add_row(gbts_pkg::OP_MOVE,   0,        0,    0,    0,     0, 0, 0,  0, 0, 0);
    add_row(gbts_pkg::OP_READ,   0,        0,    0,    0,     0, 0, 0,  0, 0, 0);
    add_row(gbts_pkg::OP_READ,   0,        2,    0,    0,     0, 0, 0,  0, 0, 0);
    add_row(gbts_pkg::OP_READ,   0,        3,    0,    0,     1, 0, 0,  2, 3, 0);
    add_row(gbts_pkg::OP_MOVE,   0,        2047, 0,    0,     1, 0, 0,  2, 3, 0);
    add_row(gbts_pkg::OP_MOVE,   0,        2,    0,    0,     0, 0, 0,  0, 0, 0);
    add_row(gbts_pkg::OP_MOVE,   0,        2,    0,    0,     0, 0, 0,  0, 0, 0);
    add_row(gbts_pkg::OP_INSERT, 'h000041, 0,    0,    0,     0, 0, 0,  0, 0, 0);
    add_row(gbts_pkg::OP_MOVE,   0,        1,    0,    0,     0, 0, 0,  0, 0, 0);
    add_row(gbts_pkg::OP_L2S,    0,        4,    0,    0,     0, 0, 0,  0, 0, 0);
    add_row(gbts_pkg::OP_L2S,    0,        5,    0,    0,     1, 0, 0,  2, 4, 1);
    add_row(gbts_pkg::OP_S2L,    0,        0,    1025, 0,     1, 0, 0,  2, 4, 1);
    add_row(gbts_pkg::OP_S2L,    0,        0,    1024, 0,     0, 0, 0,  0, 0, 0);
    add_row(gbts_pkg::OP_S2L,    0,        0,    0,    0,     0, 0, 0,  0, 0, 0);
    add_row(gbts_pkg::OP_S2L,    0,        0,    1,    0,     0, 0, 0,  0, 0, 0);
    add_row(gbts_pkg::OP_ADJUST, 0,        0,    0,    -1024, 0, 0, 0,  0, 0, 0);
    add_row(gbts_pkg::OP_ADJUST, 0,        0,    1024, 1024,  0, 0, 0,  0, 0, 0);
    add_row(gbts_pkg::OP_ADJUST, 0,        0,    1023, -2048, 0, 0, 0,  0, 0, 0);
    add_row(gbts_pkg::OP_ADJUST, 0,        0,    2047, 2047,  1, 0, 0,  2, 4, 1);
    add_row(OP_UNKNOWN,          CP_MAX,   2047, 2047, -1,    1, 0, 0,  2, 4, 1);
    add_row(gbts_pkg::OP_CLEAR,  0,        0,    0,    0,     1, 0, 0,  0, 0, 0);
    add_row(gbts_pkg::OP_READ,   0,        0,    0,    0,     1, 0, 0,  2, 0, 0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[k])
      push_request(directed_rows[k].rq, directed_rows[k].typed, directed_rows[k].res);
    drain_results();

    // no idling, then sender gaps, receiver stalls, and both
    run_random(220);
    drain_results();
    send_idle_pct = 46;
    run_random(220);
    drain_results();
    send_idle_pct = 0;
    recv_stall_pct = 46;
    run_random(220);
    drain_results();
    send_idle_pct = 25;
    recv_stall_pct = 25;
    run_random(210);

    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
